@@ rtl/sawa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the stop-and-wait ARQ endpoint.
// No dependencies; imported by every module of the block.
package sawa_pkg;

  typedef enum logic [2:0] {
    CMD_SEND     = 3'd0,
    CMD_RECV     = 3'd1,
    CMD_FRAME    = 3'd2,
    CMD_TIMEOUT  = 3'd3,
    CMD_LINK_ERR = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_RESET   = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ACT_TX_DATA   = 3'd0,
    ACT_TX_ACK    = 3'd1,
    ACT_SENT_OK   = 3'd2,
    ACT_SEND_FAIL = 3'd3,
    ACT_RECEIVED  = 3'd4,
    ACT_QUIT      = 3'd5,
    ACT_ERROR     = 3'd6
  } act_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2
  } mode_e;

  localparam int unsigned AttemptW = 4;
  localparam int unsigned CountW   = 11;
  localparam logic [AttemptW-1:0] AttemptsReset = 4'd5;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] request_length;
    logic [1:0]  frame_kind;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_ack;
    logic [10:0] frame_length;
  } item_t;

  typedef struct packed {
    logic [2:0]        action;
    logic              seq_bit;
    logic              ack_bit;
    logic [CountW-1:0] byte_count;
    logic              last;
  } result_t;

  // Results of one item: up to two, always written in order.
  typedef struct packed {
    logic    first;
    logic    second;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

@@ rtl/stop_and_wait_arq_endpoint.sv @@
`timescale 1ns / 1ps
// Top level of the alternating-bit stop-and-wait ARQ endpoint.
// Depends on sawa_pkg, sawa_core and sawa_res_queue.
//
// Usage:
//   Events enter on the s_axis channel: command in tuser, frame header and
//   request length in tdata. Each event yields zero, one or two result
//   transfers on m_axis; tlast marks the final result of an event, and tuser
//   carries the action code.
//   The cfg channel writes max_attempts; cfg_ready is always high. Write it
//   only while no event is in flight.
// Timing:
//   An event is registered on acceptance and decided from the input register
//   once the queue has room; its results are written to the result queue.
//   One event per cycle is sustained while the queue has room; two-result
//   events (in-order data received) take one queue slot more, so a long run
//   of them is limited by the single result per cycle on m_axis.
// Stalls:
//   A four-entry result queue decouples the sides. An event is decided only
//   when two queue slots are free; otherwise it holds in the input register
//   and s_axis_tready drops once that register is occupied.
// Reset:
//   Mode idle, both sequence bits zero, attempt count and held lengths zero,
//   max_attempts 5, queue empty.
module stop_and_wait_arq_endpoint import sawa_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 1024,
  parameter int unsigned HEADER_BYTES  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] request_length, [17:16] frame_kind, [25:18] frame_seq,
  // [33:26] frame_ack, [44:34] frame_length, [47:45] zero
  input  logic [47:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] seq_bit, [1] ack_bit, [12:2] byte_count, [15:13] zero
  output logic [15:0] m_axis_tdata,
  // [2:0] action
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);

  logic    in_valid_q;
  item_t   item_q;
  logic    room, fire;
  push_t   push;
  result_t res;

  assign fire          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || fire;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.command        <= s_axis_tuser;
      item_q.request_length <= s_axis_tdata[15:0];
      item_q.frame_kind     <= s_axis_tdata[17:16];
      item_q.frame_seq      <= s_axis_tdata[25:18];
      item_q.frame_ack      <= s_axis_tdata[33:26];
      item_q.frame_length   <= s_axis_tdata[44:34];
    end
  end

  sawa_core #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .HEADER_BYTES  (HEADER_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (item_q),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push_o     (push)
  );

  sawa_res_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res)
  );

  assign m_axis_tdata = {3'b0, res.byte_count, res.ack_bit, res.seq_bit};
  assign m_axis_tuser = res.action;
  assign m_axis_tlast = res.last;

endmodule

@@ rtl/sawa_core.sv @@
`timescale 1ns / 1ps
// Protocol state and per-item decision logic of the ARQ endpoint.
// Depends on sawa_pkg.
module sawa_core import sawa_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 1024,
  parameter int unsigned HEADER_BYTES  = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  item_t               item_i,
  input  logic                cfg_we_i,
  input  logic [AttemptW-1:0] cfg_data_i,
  output push_t               push_o
);

  localparam int unsigned LenW = 17;
  localparam logic [LenW-1:0] PayMax = LenW'(PAYLOAD_BYTES);
  localparam logic [LenW-1:0] HdrLen = LenW'(HEADER_BYTES);

  mode_e               mode_q, mode_d;
  logic                send_bit_q, send_bit_d;
  logic                recv_bit_q, recv_bit_d;
  logic [AttemptW-1:0] attempt_q, attempt_d;
  logic [AttemptW-1:0] max_att_q;
  logic [CountW-1:0]   held_pay_q, held_pay_d;
  logic [15:0]         held_buf_q, held_buf_d;

  logic [LenW-1:0] req_ext, req_clip, flen_ext, rx_pay, rx_clip1, rx_clip2;
  logic            sending, receiving;

  assign sending   = (mode_q == MODE_SEND);
  assign receiving = (mode_q == MODE_RECV);
  assign req_ext   = {1'b0, item_i.request_length};
  assign req_clip  = (req_ext > PayMax) ? PayMax : req_ext;
  assign flen_ext  = {6'b0, item_i.frame_length};
  assign rx_pay    = flen_ext - HdrLen;
  assign rx_clip1  = (rx_pay > PayMax) ? PayMax : rx_pay;
  assign rx_clip2  = (rx_clip1 > {1'b0, held_buf_q}) ? {1'b0, held_buf_q} : rx_clip1;

  always_comb begin
    mode_d     = mode_q;
    send_bit_d = send_bit_q;
    recv_bit_d = recv_bit_q;
    attempt_d  = attempt_q;
    held_pay_d = held_pay_q;
    held_buf_d = held_buf_q;
    push_o     = '0;
    case (item_i.command)
      CMD_SEND, CMD_RECV: begin
        if (sending || receiving) begin
          push_o.first     = 1'b1;
          push_o.r0.action = ACT_ERROR;
          push_o.r0.last   = 1'b1;
        end else if (item_i.command == CMD_SEND) begin
          held_pay_d           = req_clip[CountW-1:0];
          attempt_d            = AttemptW'(1);
          mode_d               = MODE_SEND;
          push_o.first         = 1'b1;
          push_o.r0.action     = ACT_TX_DATA;
          push_o.r0.seq_bit    = send_bit_q;
          push_o.r0.ack_bit    = recv_bit_q;
          push_o.r0.byte_count = req_clip[CountW-1:0];
          push_o.r0.last       = 1'b1;
        end else begin
          held_buf_d = item_i.request_length;
          mode_d     = MODE_RECV;
        end
      end
      CMD_FRAME: begin
        if (flen_ext >= HdrLen && (sending || receiving)) begin
          if (item_i.frame_kind == KIND_RESET) begin
            mode_d           = MODE_IDLE;
            push_o.first     = 1'b1;
            push_o.r0.action = ACT_QUIT;
            push_o.r0.last   = 1'b1;
          end else if (sending) begin
            if (item_i.frame_kind == KIND_ACK && item_i.frame_ack == {7'b0, ~send_bit_q}) begin
              send_bit_d           = ~send_bit_q;
              mode_d               = MODE_IDLE;
              push_o.first         = 1'b1;
              push_o.r0.action     = ACT_SENT_OK;
              push_o.r0.byte_count = held_pay_q;
              push_o.r0.last       = 1'b1;
            end
          end else if (item_i.frame_kind == KIND_DATA) begin
            push_o.first      = 1'b1;
            push_o.r0.action  = ACT_TX_ACK;
            if (item_i.frame_seq == {7'b0, recv_bit_q}) begin
              // In order: acknowledge with the flipped bit, then deliver.
              recv_bit_d           = ~recv_bit_q;
              mode_d               = MODE_IDLE;
              push_o.r0.ack_bit    = ~recv_bit_q;
              push_o.second        = 1'b1;
              push_o.r1.action     = ACT_RECEIVED;
              push_o.r1.byte_count = rx_clip2[CountW-1:0];
              push_o.r1.last       = 1'b1;
            end else begin
              push_o.r0.ack_bit = recv_bit_q;
              push_o.r0.last    = 1'b1;
            end
          end
        end
      end
      CMD_TIMEOUT, CMD_LINK_ERR: begin
        if (sending) begin
          push_o.first   = 1'b1;
          push_o.r0.last = 1'b1;
          if (attempt_q < max_att_q) begin
            attempt_d            = attempt_q + AttemptW'(1);
            push_o.r0.action     = ACT_TX_DATA;
            push_o.r0.seq_bit    = send_bit_q;
            push_o.r0.ack_bit    = recv_bit_q;
            push_o.r0.byte_count = held_pay_q;
          end else begin
            mode_d           = MODE_IDLE;
            push_o.r0.action = ACT_SEND_FAIL;
          end
        end else if (receiving && item_i.command == CMD_LINK_ERR) begin
          mode_d           = MODE_IDLE;
          push_o.first     = 1'b1;
          push_o.r0.action = ACT_ERROR;
          push_o.r0.last   = 1'b1;
        end
      end
      default: begin
        // Unused command codes: drop.
      end
    endcase
    if (!fire_i) push_o = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      send_bit_q <= 1'b0;
      recv_bit_q <= 1'b0;
      attempt_q  <= '0;
      held_pay_q <= '0;
      held_buf_q <= '0;
      max_att_q  <= AttemptsReset;
    end else begin
      if (fire_i) begin
        mode_q     <= mode_d;
        send_bit_q <= send_bit_d;
        recv_bit_q <= recv_bit_d;
        attempt_q  <= attempt_d;
        held_pay_q <= held_pay_d;
        held_buf_q <= held_buf_d;
      end
      if (cfg_we_i) max_att_q <= cfg_data_i;
    end
  end

`ifndef SYNTHESIS
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.second |-> push_o.first && push_o.r0.action == ACT_TX_ACK
                      && push_o.r1.action == ACT_RECEIVED && !push_o.r0.last)
    else $error("second result without ack/received pair");
  a_retx_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && sending && push_o.first && push_o.r0.action == ACT_TX_DATA
    |=> attempt_q == $past(attempt_q) + AttemptW'(1))
    else $error("retransmit did not advance attempt count");
  a_sent_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.first && push_o.r0.action == ACT_SENT_OK
    |=> send_bit_q != $past(send_bit_q) && mode_q == MODE_IDLE)
    else $error("completed send did not flip sequence bit");
`endif

endmodule

@@ rtl/sawa_res_queue.sv @@
`timescale 1ns / 1ps
// Four-entry result queue taking up to two results per cycle.
// Depends on sawa_pkg.
module sawa_res_queue import sawa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            pop;
  logic [1:0]      n_push;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;
  assign n_push  = {1'b0, push_i.first} + {1'b0, push_i.second};
  // Room for a whole item's results.
  assign room_o  = (count_q <= (PtrW+1)'(Depth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.first)  mem_q[wr_ptr_q] <= push_i.r0;
    if (push_i.second) mem_q[wr_ptr_q + PtrW'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q  <= count_q + (PtrW+1)'(n_push) - (PtrW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.first |-> count_q <= (PtrW+1)'(Depth - 2))
    else $error("result queue overflow");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_i.first && pop |=> count_q == $past(count_q) - (PtrW+1)'(1))
    else $error("queue count lost a pop");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ptr_q == rd_ptr_q + PtrW'(count_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

@@ tb/stop_and_wait_arq_endpoint_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the stop-and-wait ARQ endpoint: directed rows, then random
// send/receive exchanges, checked against an in-bench model. Depends on sawa_pkg.
module stop_and_wait_arq_endpoint_tb;
  import sawa_pkg::*;

  localparam int unsigned PayloadBytes = 1024;
  localparam int unsigned HeaderBytes  = 4;
  localparam logic [2:0]  CmdUnused    = 3'd7;
  localparam int          HoldCycles   = 64;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i;

  // Model state of the endpoint
  mode_e               arq_mode      = MODE_IDLE;
  logic                send_bit      = 1'b0;
  logic                recv_bit      = 1'b0;
  logic [AttemptW-1:0] attempts      = '0;
  logic [AttemptW-1:0] attempt_limit = AttemptsReset;
  logic [CountW-1:0]   held_len      = '0;
  logic [15:0]         buf_len       = '0;

  result_t awaited_results[$];
  int      offered_items  = 0;
  int      bad_count      = 0;
  int      send_idle_pct  = 0;
  int      recv_idle_pct  = 0;
  int      hold_asks      = 0;
  int      hold_done      = 0;
  bit      drv_typed;
  result_t drv_typed_res;

  stop_and_wait_arq_endpoint #(
    .PAYLOAD_BYTES(PayloadBytes),
    .HEADER_BYTES (HeaderBytes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic item_t mk_item(logic [2:0] cmd, logic [15:0] req, logic [1:0] kind,
                                    logic [7:0] seq, logic [7:0] ack, logic [10:0] flen);
    item_t it;
    it.command        = cmd;
    it.request_length = req;
    it.frame_kind     = kind;
    it.frame_seq      = seq;
    it.frame_ack      = ack;
    it.frame_length   = flen;
    return it;
  endfunction

  function automatic result_t mk_res(act_e act, logic sq, logic ak, logic [CountW-1:0] cnt,
                                     logic lst);
    result_t r;
    r.action     = act;
    r.seq_bit    = sq;
    r.ack_bit    = ak;
    r.byte_count = cnt;
    r.last       = lst;
    return r;
  endfunction

  // Advance the endpoint model by one event; returns the number of results.
  function automatic int arq_decide(input item_t it, output result_t r0, output result_t r1);
    int pay;
    r0 = '0;
    r1 = '0;
    case (it.command)
      CMD_SEND, CMD_RECV: begin
        if (arq_mode != MODE_IDLE) begin
          r0 = mk_res(ACT_ERROR, 1'b0, 1'b0, '0, 1'b1);
          return 1;
        end
        if (it.command == CMD_SEND) begin
          held_len = (it.request_length > PayloadBytes) ? CountW'(PayloadBytes)
                                                        : it.request_length[CountW-1:0];
          attempts = AttemptW'(1);
          arq_mode = MODE_SEND;
          r0 = mk_res(ACT_TX_DATA, send_bit, recv_bit, held_len, 1'b1);
          return 1;
        end
        buf_len  = it.request_length;
        arq_mode = MODE_RECV;
        return 0;
      end
      CMD_FRAME: begin
        if (it.frame_length < HeaderBytes || arq_mode == MODE_IDLE) return 0;
        if (it.frame_kind == KIND_RESET) begin
          arq_mode = MODE_IDLE;
          r0 = mk_res(ACT_QUIT, 1'b0, 1'b0, '0, 1'b1);
          return 1;
        end
        if (arq_mode == MODE_SEND) begin
          if (it.frame_kind == KIND_ACK && it.frame_ack == {7'd0, ~send_bit}) begin
            send_bit = ~send_bit;
            arq_mode = MODE_IDLE;
            r0 = mk_res(ACT_SENT_OK, 1'b0, 1'b0, held_len, 1'b1);
            return 1;
          end
          return 0;
        end
        if (it.frame_kind != KIND_DATA) return 0;
        if (it.frame_seq == {7'd0, recv_bit}) begin
          pay = int'(it.frame_length) - int'(HeaderBytes);
          if (pay > int'(PayloadBytes)) pay = int'(PayloadBytes);
          if (pay > int'(buf_len)) pay = int'(buf_len);
          recv_bit = ~recv_bit;
          arq_mode = MODE_IDLE;
          r0 = mk_res(ACT_TX_ACK, 1'b0, recv_bit, '0, 1'b0);
          r1 = mk_res(ACT_RECEIVED, 1'b0, 1'b0, CountW'(pay), 1'b1);
          return 2;
        end
        // duplicate: acknowledge again
        r0 = mk_res(ACT_TX_ACK, 1'b0, recv_bit, '0, 1'b1);
        return 1;
      end
      CMD_TIMEOUT, CMD_LINK_ERR: begin
        if (arq_mode == MODE_SEND) begin
          if (attempts < attempt_limit) begin
            attempts = attempts + AttemptW'(1);
            r0 = mk_res(ACT_TX_DATA, send_bit, recv_bit, held_len, 1'b1);
            return 1;
          end
          arq_mode = MODE_IDLE;
          r0 = mk_res(ACT_SEND_FAIL, 1'b0, 1'b0, '0, 1'b1);
          return 1;
        end
        if (arq_mode == MODE_RECV && it.command == CMD_LINK_ERR) begin
          arq_mode = MODE_IDLE;
          r0 = mk_res(ACT_ERROR, 1'b0, 1'b0, '0, 1'b1);
          return 1;
        end
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  task automatic report_failure(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : scoreboard
    result_t got, want, r0, r1;
    item_t   it;
    int      n;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.action     = m_axis_tuser;
        got.seq_bit    = m_axis_tdata[0];
        got.ack_bit    = m_axis_tdata[1];
        got.byte_count = m_axis_tdata[12:2];
        got.last       = m_axis_tlast;
        if (awaited_results.size() == 0) begin
          report_failure($sformatf("unexpected result act %0d cnt %0d", got.action,
                                   got.byte_count));
        end else begin
          want = awaited_results.pop_front();
          if (got.action !== want.action || got.seq_bit !== want.seq_bit ||
              got.ack_bit !== want.ack_bit || got.byte_count !== want.byte_count ||
              got.last !== want.last)
            report_failure($sformatf(
              "result differs: exp act %0d seq %0d ack %0d cnt %0d last %0d, got %0d %0d %0d %0d %0d",
              want.action, want.seq_bit, want.ack_bit, want.byte_count, want.last,
              got.action, got.seq_bit, got.ack_bit, got.byte_count, got.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it = mk_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[17:16],
                     s_axis_tdata[25:18], s_axis_tdata[33:26], s_axis_tdata[44:34]);
        n = arq_decide(it, r0, r1);
        if (drv_typed) begin
          awaited_results.push_back(drv_typed_res);
        end else begin
          if (n > 0) awaited_results.push_back(r0);
          if (n > 1) awaited_results.push_back(r1);
        end
      end
      if (cfg_valid_i && cfg_ready_o) attempt_limit = cfg_data_i;
    end
  end

  // Result side: random back-pressure, plus a long counted hold on request.
  initial begin : receiver
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_done) begin
        hold_done++;
        for (int k = 0; k < HoldCycles; k++) begin
          m_axis_tready <= 1'b0;
          @(posedge clk_i);
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic offer(input item_t it, input bit typed, input result_t tres);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'd0, it.frame_length, it.frame_ack, it.frame_seq, it.frame_kind,
                      it.request_length};
    s_axis_tuser  <= it.command;
    drv_typed     <= typed;
    drv_typed_res <= tres;
    do @(posedge clk_i); while (!s_axis_tready);
    offered_items++;
  endtask

  // Hold the input and wait for every awaited result, then let in-flight events settle.
  task automatic drain_results();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_attempt_limit(input logic [3:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 16'($urandom_range(0, 64));
    if (p < 80) return 16'($urandom_range(1000, 1100));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [10:0] rand_flen();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) return 11'($urandom_range(0, HeaderBytes - 1));
    if (p < 65) return 11'($urandom_range(HeaderBytes, 80));
    return 11'($urandom_range(900, 1028));
  endfunction

  function automatic logic [7:0] rand_bitfield();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic item_t rand_item();
    logic [2:0] cmd;
    cmd = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
    return mk_item(cmd, 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   11'($urandom_range(0, 1028)));
  endfunction

  // Mostly complete send and receive exchanges, with some noise between them.
  task automatic run_random(input int target);
    int    start, pick, e;
    item_t it;
    start = offered_items;
    while (offered_items - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        it = rand_item();
        it.command = CMD_SEND;
        it.request_length = rand_len();
        offer(it, 1'b0, '0);
        repeat ($urandom_range(1, 8)) begin
          it = rand_item();
          e = $urandom_range(0, 99);
          if (e < 35) it.command = CMD_TIMEOUT;
          else if (e < 50) it.command = CMD_LINK_ERR;
          else if (e < 90) begin
            it.command      = CMD_FRAME;
            it.frame_kind   = (e < 85) ? KIND_ACK : KIND_RESET;
            it.frame_ack    = rand_bitfield();
            it.frame_length = rand_flen();
          end
          offer(it, 1'b0, '0);
        end
      end else if (pick < 85) begin
        it = rand_item();
        it.command = CMD_RECV;
        it.request_length = rand_len();
        offer(it, 1'b0, '0);
        repeat ($urandom_range(1, 5)) begin
          it = rand_item();
          e = $urandom_range(0, 99);
          if (e < 55) begin
            it.command      = CMD_FRAME;
            it.frame_kind   = KIND_DATA;
            it.frame_seq    = rand_bitfield();
            it.frame_length = rand_flen();
          end else if (e < 65) it.command = CMD_TIMEOUT;
          else if (e < 70) it.command = CMD_LINK_ERR;
          else if (e < 75) begin
            it.command    = CMD_FRAME;
            it.frame_kind = KIND_RESET;
          end
          offer(it, 1'b0, '0);
        end
      end else begin
        repeat (3) offer(rand_item(), 1'b0, '0);
      end
    end
  endtask

  initial begin : stimulus
    stim_row_t   rows[$];
    int          limits[6];
    logic [3:0]  lim;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    drv_typed     = 1'b0;
    drv_typed_res = '0;
    rst_ni        = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 81;
    limits = '{1, 15, 0, -1, 5, -1};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // idle-mode events are dropped
    rows.push_back('{mk_item(CMD_FRAME, 16'd0, KIND_DATA, 8'd0, 8'd0, 11'd4), 1'b0, '0});
    rows.push_back('{mk_item(CMD_TIMEOUT, 16'd0, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b0, '0});
    rows.push_back('{mk_item(CmdUnused, 16'hFFFF, KIND_UNKNOWN, 8'hFF, 8'hFF, 11'd1028),
                     1'b0, '0});
    // send path: truncation, busy requests, ignored frames, retransmit to the limit
    rows.push_back('{mk_item(CMD_SEND, 16'hFFFF, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b1,
                     mk_res(ACT_TX_DATA, 1'b0, 1'b0, 11'd1024, 1'b1)});
    rows.push_back('{mk_item(CMD_SEND, 16'd5, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b1,
                     mk_res(ACT_ERROR, 1'b0, 1'b0, 11'd0, 1'b1)});
    rows.push_back('{mk_item(CMD_RECV, 16'd5, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b1,
                     mk_res(ACT_ERROR, 1'b0, 1'b0, 11'd0, 1'b1)});
    rows.push_back('{mk_item(CMD_FRAME, 16'd0, KIND_DATA, 8'd0, 8'd1, 11'd100), 1'b0, '0});
    rows.push_back('{mk_item(CMD_FRAME, 16'd0, KIND_ACK, 8'd0, 8'd0, 11'd4), 1'b0, '0});
    rows.push_back('{mk_item(CMD_FRAME, 16'd0, KIND_ACK, 8'd0, 8'd255, 11'd4), 1'b0, '0});
    rows.push_back('{mk_item(CMD_FRAME, 16'd0, KIND_ACK, 8'd0, 8'd1, 11'd3), 1'b0, '0});
    rows.push_back('{mk_item(CMD_TIMEOUT, 16'd0, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b0, '0});
    rows.push_back('{mk_item(CMD_LINK_ERR, 16'd0, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b0, '0});
    rows.push_back('{mk_item(CMD_TIMEOUT, 16'd0, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b0, '0});
    rows.push_back('{mk_item(CMD_TIMEOUT, 16'd0, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b0, '0});
    rows.push_back('{mk_item(CMD_TIMEOUT, 16'd0, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b1,
                     mk_res(ACT_SEND_FAIL, 1'b0, 1'b0, 11'd0, 1'b1)});
    rows.push_back('{mk_item(CMD_SEND, 16'd0, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b1,
                     mk_res(ACT_TX_DATA, 1'b0, 1'b0, 11'd0, 1'b1)});
    rows.push_back('{mk_item(CMD_FRAME, 16'd0, KIND_ACK, 8'd0, 8'd1, 11'd4), 1'b1,
                     mk_res(ACT_SENT_OK, 1'b0, 1'b0, 11'd0, 1'b1)});
    // receive path: ignored events, duplicate, in-order delivery, buffer clip
    rows.push_back('{mk_item(CMD_RECV, 16'hFFFF, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b0, '0});
    rows.push_back('{mk_item(CMD_TIMEOUT, 16'd0, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b0, '0});
    rows.push_back('{mk_item(CMD_FRAME, 16'd0, KIND_UNKNOWN, 8'd0, 8'd0, 11'd50), 1'b0, '0});
    rows.push_back('{mk_item(CMD_FRAME, 16'd0, KIND_DATA, 8'd1, 8'd0, 11'd1028), 1'b0, '0});
    rows.push_back('{mk_item(CMD_FRAME, 16'd0, KIND_DATA, 8'd0, 8'd0, 11'd1028), 1'b0, '0});
    rows.push_back('{mk_item(CMD_RECV, 16'd10, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b0, '0});
    rows.push_back('{mk_item(CMD_FRAME, 16'd0, KIND_DATA, 8'd1, 8'd0, 11'd1028), 1'b0, '0});
    rows.push_back('{mk_item(CMD_RECV, 16'd0, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b0, '0});
    rows.push_back('{mk_item(CMD_LINK_ERR, 16'd0, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b1,
                     mk_res(ACT_ERROR, 1'b0, 1'b0, 11'd0, 1'b1)});
    // a reset frame ends a send in progress
    rows.push_back('{mk_item(CMD_SEND, 16'd1025, KIND_DATA, 8'd0, 8'd0, 11'd0), 1'b0, '0});
    rows.push_back('{mk_item(CMD_FRAME, 16'd0, KIND_RESET, 8'd0, 8'd0, 11'd4), 1'b1,
                     mk_res(ACT_QUIT, 1'b0, 1'b0, 11'd0, 1'b1)});

    foreach (rows[i]) offer(rows[i].it, rows[i].typed, rows[i].res);
    drain_results();

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 33 : (p < 4) ? 81 : 0;
      recv_idle_pct = (p < 2) ? 81 : (p < 4) ? 33 : 0;
      lim = (limits[p] < 0) ? 4'($urandom_range(1, 14)) : 4'(limits[p]);
      set_attempt_limit(lim);
      // stall the result side while the sender keeps offering
      if (p == 4) hold_asks++;
      if (p == 5) begin
        run_random(75);
        drain_results();
        run_random(75);
      end else begin
        run_random(150);
      end
      drain_results();
    end

    if (awaited_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", awaited_results.size()));
    if (bad_count == 0) begin
      $display("stop_and_wait_arq_endpoint: match");
    end else begin
      $display("stop_and_wait_arq_endpoint: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(4_000_000);
    $display("stop_and_wait_arq_endpoint: mismatch");
    $finish;
  end

endmodule
